// ===== src/ael_pkg.sv =====
// Shared types, constants and codes of the aged endpoint list.
package ael_pkg;

    localparam int DEPTH_DEF    = 2048;
    localparam int MAX_LIST_DEF = 16;

    localparam int PADDR_W   = 5;
    localparam int CNT_OUT_W = 12;

    localparam logic [10:0] HIGH_RST = 11'd1500;
    localparam logic [10:0] LOW_RST  = 11'd500;
    localparam logic [31:0] AGE_RST  = 32'd86400;
    localparam logic [15:0] DAGE_RST = 16'd60;
    localparam logic [4:0]  TOP_RST  = 5'd10;

    localparam logic [2:0] CFG_HIGH = 3'd0;
    localparam logic [2:0] CFG_LOW  = 3'd1;
    localparam logic [2:0] CFG_AGE  = 3'd2;
    localparam logic [2:0] CFG_DAGE = 3'd3;
    localparam logic [2:0] CFG_TOP  = 3'd4;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_TOUCH  = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_POP    = 3'd3;
    localparam logic [2:0] REQ_LIST   = 3'd4;
    localparam logic [2:0] REQ_PRUNE  = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REJECT  = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] host_ip;
        logic [15:0] host_port;
        logic [31:0] entry_time;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_ip;
        logic [15:0] out_port;
        logic [31:0] out_time;
        logic [11:0] entry_count;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_UP_RD,
        ST_UP_WR,
        ST_PUT,
        ST_CMP_RD,
        ST_CMP_EV,
        ST_POP_RD,
        ST_POP_EV,
        ST_LST_RD,
        ST_LST_EV,
        ST_RESP
    } state_t;

endpackage

// ===== src/ael_store.sv =====
// Entry memory: one write port and one registered read port.
module ael_store #(
    parameter int DEPTH = ael_pkg::DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ael_pkg::entry_t      wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output ael_pkg::entry_t      rd_data
);

    ael_pkg::entry_t mem [DEPTH];
    ael_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/aged_endpoint_list_top.sv =====
// Top level of the aged endpoint list: request sequencer, registers and entry memory.
// The list is held newest first in one memory; every request walks it entry by entry
// through the single read port. A lookup scans from the head; an insertion or refresh
// then shifts the entries in its way down by one. Remove, pop and prune compact the
// list in place, and a list request reads out the newest entries. One request is
// handled at a time; the next is taken while the final result still waits in the
// output register.
module aged_endpoint_list_top #(
    parameter int DEPTH    = ael_pkg::DEPTH_DEF,
    parameter int MAX_LIST = ael_pkg::MAX_LIST_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ael_pkg::req_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ael_pkg::rsp_t               m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ael_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = $clog2(MAX_LIST + 1);
    localparam int OCW   = ael_pkg::CNT_OUT_W;

    ael_pkg::state_t state_reg, state_next;
    ael_pkg::req_t   req_reg, req_next;
    ael_pkg::entry_t new_reg, new_next;
    ael_pkg::entry_t pop_reg, pop_next;
    ael_pkg::rsp_t   m_data_reg, m_data_next;
    logic            m_valid_reg, m_valid_next;

    logic [31:0]      t_reg, t_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] stop_reg, stop_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic             older_reg, older_next;
    logic             inc_reg, inc_next;
    logic             prune_reg, prune_next;
    logic [LW-1:0]    lst_reg, lst_next;
    logic [LW-1:0]    n_reg, n_next;
    logic [1:0]       status_reg, status_next;

    logic [10:0] high_mark_reg;
    logic [10:0] low_mark_reg;
    logic [31:0] max_age_reg;
    logic [15:0] default_age_reg;
    logic [4:0]  top_count_reg;

    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    ael_pkg::entry_t  wr_data, rd_data;

    logic             match, older, idx_end, keep, out_free, lst_last, add_bad;
    logic [CNT_W-1:0] trim_cnt, cnt_cap;
    logic [IDX_W-1:0] ins_pos;
    logic [31:0]      t_eff, n_wide;
    logic             cfg_wr;

    ael_store #(.DEPTH(DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_mark_reg   <= ael_pkg::HIGH_RST;
            low_mark_reg    <= ael_pkg::LOW_RST;
            max_age_reg     <= ael_pkg::AGE_RST;
            default_age_reg <= ael_pkg::DAGE_RST;
            top_count_reg   <= ael_pkg::TOP_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                ael_pkg::CFG_HIGH: high_mark_reg   <= pwdata[10:0];
                ael_pkg::CFG_LOW:  low_mark_reg    <= pwdata[10:0];
                ael_pkg::CFG_AGE:  max_age_reg     <= pwdata;
                ael_pkg::CFG_DAGE: default_age_reg <= pwdata[15:0];
                ael_pkg::CFG_TOP:  top_count_reg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            ael_pkg::CFG_HIGH: prdata = 32'(high_mark_reg);
            ael_pkg::CFG_LOW:  prdata = 32'(low_mark_reg);
            ael_pkg::CFG_AGE:  prdata = max_age_reg;
            ael_pkg::CFG_DAGE: prdata = 32'(default_age_reg);
            ael_pkg::CFG_TOP:  prdata = 32'(top_count_reg);
            default:           prdata = 32'd0;
        endcase
    end

    assign s_ready  = (state_reg == ael_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign match   = (rd_data.addr == req_reg.host_ip) && (rd_data.port == req_reg.host_port);
    assign older   = rd_data.stamp < t_reg;
    assign idx_end = idx_reg >= cnt_reg;
    assign keep    = !prune_reg || ((req_reg.now - rd_data.stamp) <= max_age_reg);
    assign lst_last = (LW'(lst_reg + LW'(1)) == n_reg);
    assign add_bad = (req_reg.host_ip == 32'd0) || (req_reg.host_port == 16'd0);

    assign trim_cnt = (32'(cnt_reg) > 32'(high_mark_reg)) && (32'(cnt_reg) > 32'(low_mark_reg))
                      ? CNT_W'(low_mark_reg) : cnt_reg;
    assign t_eff = (req_reg.entry_time == 32'd0) ? req_reg.now - 32'(default_age_reg)
                                                 : req_reg.entry_time;
    assign cnt_cap = (cnt_reg == CNT_W'(DEPTH)) ? CNT_W'(DEPTH - 1) : cnt_reg;
    assign ins_pos = (older_reg && (CNT_W'(first_reg) < cnt_cap)) ? first_reg
                                                                  : IDX_W'(cnt_cap);

    always_comb begin
        n_wide = 32'(top_count_reg);
        if (32'(cnt_reg) < n_wide) begin
            n_wide = 32'(cnt_reg);
        end
        if (32'(MAX_LIST) < n_wide) begin
            n_wide = 32'(MAX_LIST);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ael_pkg::ST_IDLE: begin
                if (s_valid) state_next = ael_pkg::ST_START;
            end
            ael_pkg::ST_START: begin
                case (req_reg.req_type)
                    ael_pkg::REQ_ADD:
                        state_next = add_bad ? ael_pkg::ST_RESP : ael_pkg::ST_SCAN_RD;
                    ael_pkg::REQ_TOUCH, ael_pkg::REQ_REMOVE:
                        state_next = ael_pkg::ST_SCAN_RD;
                    ael_pkg::REQ_POP:
                        state_next = (cnt_reg == '0) ? ael_pkg::ST_RESP : ael_pkg::ST_POP_RD;
                    ael_pkg::REQ_LIST:
                        state_next = (n_wide == 32'd0) ? ael_pkg::ST_RESP : ael_pkg::ST_LST_RD;
                    ael_pkg::REQ_PRUNE:
                        state_next = ael_pkg::ST_CMP_RD;
                    default:
                        state_next = ael_pkg::ST_RESP;
                endcase
            end
            ael_pkg::ST_SCAN_RD: begin
                if (!idx_end) begin
                    state_next = ael_pkg::ST_SCAN_EV;
                end else if (req_reg.req_type == ael_pkg::REQ_ADD) begin
                    state_next = ael_pkg::ST_UP_RD;
                end else begin
                    state_next = ael_pkg::ST_RESP;
                end
            end
            ael_pkg::ST_SCAN_EV: begin
                if (!match) begin
                    state_next = ael_pkg::ST_SCAN_RD;
                end else if (req_reg.req_type == ael_pkg::REQ_ADD) begin
                    state_next = older ? ael_pkg::ST_UP_RD : ael_pkg::ST_RESP;
                end else if (req_reg.req_type == ael_pkg::REQ_TOUCH) begin
                    state_next = ael_pkg::ST_UP_RD;
                end else begin
                    state_next = ael_pkg::ST_CMP_RD;
                end
            end
            ael_pkg::ST_UP_RD:
                state_next = (j_reg == stop_reg) ? ael_pkg::ST_PUT : ael_pkg::ST_UP_WR;
            ael_pkg::ST_UP_WR: state_next = ael_pkg::ST_UP_RD;
            ael_pkg::ST_PUT:   state_next = ael_pkg::ST_RESP;
            ael_pkg::ST_CMP_RD:
                state_next = idx_end ? ael_pkg::ST_RESP : ael_pkg::ST_CMP_EV;
            ael_pkg::ST_CMP_EV: state_next = ael_pkg::ST_CMP_RD;
            ael_pkg::ST_POP_RD: state_next = ael_pkg::ST_POP_EV;
            ael_pkg::ST_POP_EV: state_next = ael_pkg::ST_CMP_RD;
            ael_pkg::ST_LST_RD: state_next = ael_pkg::ST_LST_EV;
            ael_pkg::ST_LST_EV: begin
                if (out_free) state_next = lst_last ? ael_pkg::ST_IDLE : ael_pkg::ST_LST_RD;
            end
            ael_pkg::ST_RESP: begin
                if (out_free) state_next = ael_pkg::ST_IDLE;
            end
            default: state_next = ael_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        req_next     = req_reg;
        new_next     = new_reg;
        pop_next     = pop_reg;
        t_next       = t_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        w_next       = w_reg;
        j_next       = j_reg;
        stop_next    = stop_reg;
        first_next   = first_reg;
        older_next   = older_reg;
        inc_next     = inc_reg;
        prune_next   = prune_reg;
        lst_next     = lst_reg;
        n_next       = n_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        wr_addr      = j_reg;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[IDX_W-1:0];

        case (state_reg)
            ael_pkg::ST_IDLE: begin
                if (s_valid) req_next = s_data;
            end
            ael_pkg::ST_START: begin
                status_next = ael_pkg::STAT_OK;
                pop_next    = '0;
                idx_next    = '0;
                w_next      = '0;
                older_next  = 1'b0;
                prune_next  = 1'b0;
                lst_next    = '0;
                n_next      = LW'(n_wide);
                case (req_reg.req_type)
                    ael_pkg::REQ_ADD: begin
                        if (add_bad) begin
                            status_next = ael_pkg::STAT_REJECT;
                        end else begin
                            cnt_next = trim_cnt;
                            t_next   = t_eff;
                        end
                    end
                    ael_pkg::REQ_TOUCH, ael_pkg::REQ_REMOVE: ;
                    ael_pkg::REQ_POP: begin
                        if (cnt_reg == '0) status_next = ael_pkg::STAT_MISSING;
                    end
                    ael_pkg::REQ_LIST: begin
                        if (n_wide == 32'd0) status_next = ael_pkg::STAT_MISSING;
                    end
                    ael_pkg::REQ_PRUNE: prune_next = 1'b1;
                    default: status_next = ael_pkg::STAT_REJECT;
                endcase
            end
            ael_pkg::ST_SCAN_RD: begin
                if (!idx_end) begin
                    rd_en = 1'b1;
                end else if (req_reg.req_type == ael_pkg::REQ_ADD) begin
                    cnt_next  = cnt_cap;
                    j_next    = IDX_W'(cnt_cap);
                    stop_next = ins_pos;
                    new_next  = '{req_reg.host_ip, req_reg.host_port, t_reg};
                    inc_next  = 1'b1;
                end else begin
                    status_next = ael_pkg::STAT_MISSING;
                end
            end
            ael_pkg::ST_SCAN_EV: begin
                if (older && !older_reg) begin
                    older_next = 1'b1;
                    first_next = idx_reg[IDX_W-1:0];
                end
                if (match) begin
                    j_next    = idx_reg[IDX_W-1:0];
                    stop_next = '0;
                    new_next  = '{req_reg.host_ip, req_reg.host_port, req_reg.now};
                    inc_next  = 1'b0;
                    idx_next  = CNT_W'(idx_reg + CNT_W'(1));
                    w_next    = idx_reg;
                end else begin
                    idx_next = CNT_W'(idx_reg + CNT_W'(1));
                end
            end
            ael_pkg::ST_UP_RD: begin
                if (j_reg != stop_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(j_reg - IDX_W'(1));
                end
            end
            ael_pkg::ST_UP_WR: begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = rd_data;
                j_next  = IDX_W'(j_reg - IDX_W'(1));
            end
            ael_pkg::ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = stop_reg;
                wr_data = new_reg;
                if (inc_reg) cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
            end
            ael_pkg::ST_CMP_RD: begin
                if (idx_end) begin
                    cnt_next = w_reg;
                end else begin
                    rd_en = 1'b1;
                end
            end
            ael_pkg::ST_CMP_EV: begin
                if (keep) begin
                    wr_en   = 1'b1;
                    wr_addr = w_reg[IDX_W-1:0];
                    wr_data = rd_data;
                    w_next  = CNT_W'(w_reg + CNT_W'(1));
                end
                idx_next = CNT_W'(idx_reg + CNT_W'(1));
            end
            ael_pkg::ST_POP_RD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ael_pkg::ST_POP_EV: begin
                pop_next = rd_data;
                idx_next = CNT_W'(1);
                w_next   = '0;
            end
            ael_pkg::ST_LST_RD: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(lst_reg);
            end
            ael_pkg::ST_LST_EV: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{ael_pkg::STAT_OK, rd_data.addr, rd_data.port,
                                     rd_data.stamp, OCW'(cnt_reg), lst_last};
                    lst_next     = LW'(lst_reg + LW'(1));
                end
            end
            ael_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status_reg, pop_reg.addr, pop_reg.port,
                                     pop_reg.stamp, OCW'(cnt_reg), 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ael_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        new_reg    <= new_next;
        pop_reg    <= pop_next;
        t_reg      <= t_next;
        idx_reg    <= idx_next;
        w_reg      <= w_next;
        j_reg      <= j_next;
        stop_reg   <= stop_next;
        first_reg  <= first_next;
        older_reg  <= older_next;
        inc_reg    <= inc_next;
        prune_reg  <= prune_next;
        lst_reg    <= lst_next;
        n_reg      <= n_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(DEPTH))
        else $error("entry count beyond depth");

    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ael_pkg::ST_UP_WR || state_reg == ael_pkg::ST_PUT ||
                   state_reg == ael_pkg::ST_CMP_EV))
        else $error("memory written outside a write step");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ael_pkg::ST_START))
        else $error("accepted request not started");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending result overwritten");
`endif

endmodule
